### design/spnp_pkg.sv
`default_nettype none

package spnp_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int VALUE_W = 64;
   localparam int FRAC_W  = 5;
   localparam int STEPS_W = 3;

   localparam logic [1:0] CSR_FRACTION_DIGITS = 2'd0;
   localparam logic [1:0] CSR_BINARY_PREFIX   = 2'd1;
   localparam logic [1:0] CSR_SIGNED_MODE     = 2'd2;

   typedef struct packed {
      logic [FRAC_W-1:0] fraction_digits;
      logic              binary_prefix;
      logic              signed_mode;
   } cfg_type;

   // one finished text, handed from the character front end to the scaler
   typedef struct packed {
      logic [VALUE_W-1:0] accumulator;
      logic [FRAC_W-1:0]  fraction_count;
      logic [STEPS_W-1:0] prefix_steps;
      logic               negative;
      logic               error;
      cfg_type            cfg;
   } job_type;

endpackage

`default_nettype wire

### design/spnp_front.sv
`default_nettype none

module spnp_front (
   input  wire                  clock,
   input  wire                  reset,
   input  spnp_pkg::cfg_type    cfg,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_char_code,
   input  wire                  req_last_char,
   output logic                 job_valid,
   input  wire                  job_ready,
   output spnp_pkg::job_type    job
);
   import spnp_pkg::*;

   localparam logic [2:0] PH_LEAD  = 3'd0;
   localparam logic [2:0] PH_SIGN  = 3'd1;
   localparam logic [2:0] PH_INT   = 3'd2;
   localparam logic [2:0] PH_FRAC  = 3'd3;
   localparam logic [2:0] PH_TRAIL = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   logic [2:0]         phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [FRAC_W-1:0]  fcount_ff, fcount_in;
   logic [STEPS_W-1:0] pfx_ff, pfx_in;
   logic               neg_ff, neg_in;
   logic               err_ff, err_in;

   logic               digit;
   logic               take_digit;
   logic [STEPS_W-1:0] pfx_code;
   logic [VALUE_W+3:0] times_ten;
   logic               accept;

   always_comb begin
      case (req_char_code)
         8'h6B:   pfx_code = 3'd1;   // k
         8'h4D:   pfx_code = 3'd2;   // M
         8'h47:   pfx_code = 3'd3;   // G
         8'h54:   pfx_code = 3'd4;   // T
         8'h50:   pfx_code = 3'd5;   // P
         8'h45:   pfx_code = 3'd6;   // E
         default: pfx_code = 3'd0;
      endcase
   end

   assign digit     = req_char_code inside {[8'h30:8'h39]};
   assign times_ten = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                    + {{VALUE_W{1'b0}}, req_char_code[3:0]};

   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      fcount_in  = fcount_ff;
      pfx_in     = pfx_ff;
      neg_in     = neg_ff;
      err_in     = err_ff;
      take_digit = 1'b0;
      if (!err_ff) begin
         case (phase_ff)
            PH_LEAD: begin
               if (req_char_code == CH_SPACE || req_char_code inside {[8'h09:8'h0D]}) begin
                  phase_in = PH_LEAD;
               end else if (req_char_code == CH_PLUS) begin
                  phase_in = PH_SIGN;
               end else if (req_char_code == CH_MINUS) begin
                  if (cfg.signed_mode) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGN;
                  end else begin
                     err_in = 1'b1;
                  end
               end else if (digit) begin
                  take_digit = 1'b1;
                  phase_in   = PH_INT;
               end else if (req_char_code == CH_DOT) begin
                  phase_in = PH_FRAC;
               end else if (pfx_code != 3'd0) begin
                  pfx_in   = pfx_code;
                  phase_in = PH_DONE;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_SIGN: begin
               if (digit) begin
                  take_digit = 1'b1;
                  phase_in   = PH_INT;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_INT, PH_FRAC: begin
               if (digit) begin
                  if (phase_ff == PH_INT) begin
                     take_digit = 1'b1;
                  end else if (fcount_ff < cfg.fraction_digits) begin
                     take_digit = 1'b1;
                     fcount_in  = fcount_ff + 1'b1;
                  end else begin
                     err_in = 1'b1;
                  end
               end else if (req_char_code == CH_DOT && phase_ff == PH_INT) begin
                  phase_in = PH_FRAC;
               end else if (req_char_code == CH_SPACE) begin
                  phase_in = PH_TRAIL;
               end else if (pfx_code != 3'd0) begin
                  pfx_in   = pfx_code;
                  phase_in = PH_DONE;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_TRAIL: begin
               if (req_char_code == CH_SPACE) begin
                  phase_in = PH_TRAIL;
               end else if (pfx_code != 3'd0) begin
                  pfx_in   = pfx_code;
                  phase_in = PH_DONE;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
         if (take_digit) begin
            if (|times_ten[VALUE_W+3:VALUE_W]) begin
               err_in = 1'b1;
               acc_in = '0;
            end else begin
               acc_in = times_ten[VALUE_W-1:0];
            end
         end
      end
   end

   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;
   assign job_valid = req_valid && req_last_char;

   always_comb begin
      job.accumulator    = acc_in;
      job.fraction_count = fcount_in;
      job.prefix_steps   = pfx_in;
      job.negative       = neg_in;
      // a sign with no digit after it is a fault
      job.error          = err_in || (phase_in == PH_SIGN);
      job.cfg            = cfg;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_char)) begin
         phase_ff  <= PH_LEAD;
         acc_ff    <= '0;
         fcount_ff <= '0;
         pfx_ff    <= '0;
         neg_ff    <= 1'b0;
         err_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         fcount_ff <= fcount_in;
         pfx_ff    <= pfx_in;
         neg_ff    <= neg_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire

### design/spnp_queue.sv
`default_nettype none

module spnp_queue #(
   parameter int DEPTH = spnp_pkg::QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  spnp_pkg::job_type    in_job,
   output logic                 out_valid,
   input  wire                  out_ready,
   output spnp_pkg::job_type    out_job
);
   import spnp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   job_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### design/spnp_back.sv
`default_nettype none

module spnp_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  job_valid,
   output logic                 job_ready,
   input  spnp_pkg::job_type    job,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [63:0]          rsp_parsed_value,
   output logic                 rsp_parse_error
);
   import spnp_pkg::*;

   localparam logic [VALUE_W-1:0] MIN_NEG_MAG = {1'b1, {(VALUE_W-1){1'b0}}};

   logic               busy_ff;
   logic [VALUE_W-1:0] v_ff, v_in;
   logic [FRAC_W-1:0]  tens_ff, tens_in;
   logic [STEPS_W-1:0] pfx_ff, pfx_in;
   logic               neg_ff, err_ff, err_in, bin_ff, smode_ff;
   logic               out_valid_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_error_ff;

   logic [VALUE_W+3:0] times_ten;
   logic [VALUE_W+9:0] times_prefix;
   logic               finishing, out_free, load;
   logic [VALUE_W-1:0] fin_value;
   logic               fin_error;

   assign times_ten    = {1'b0, v_ff, 3'b000} + {3'b000, v_ff, 1'b0};
   assign times_prefix = bin_ff ? {v_ff, 10'b0}
                                : ({v_ff, 10'b0} - {6'b0, v_ff, 4'b0} - {7'b0, v_ff, 3'b0});

   // pad missing fraction digits first, then apply the prefix steps
   always_comb begin
      v_in      = v_ff;
      tens_in   = tens_ff;
      pfx_in    = pfx_ff;
      err_in    = err_ff;
      finishing = 1'b0;
      if (!err_ff && tens_ff != '0) begin
         tens_in = tens_ff - 1'b1;
         if (|times_ten[VALUE_W+3:VALUE_W]) begin
            err_in = 1'b1;
         end else begin
            v_in = times_ten[VALUE_W-1:0];
         end
      end else if (!err_ff && pfx_ff != '0) begin
         pfx_in = pfx_ff - 1'b1;
         if (|times_prefix[VALUE_W+9:VALUE_W]) begin
            err_in = 1'b1;
         end else begin
            v_in = times_prefix[VALUE_W-1:0];
         end
      end else begin
         finishing = 1'b1;
      end
   end

   always_comb begin
      fin_error = err_ff;
      fin_value = v_ff;
      if (!err_ff) begin
         if (neg_ff) begin
            if (v_ff > MIN_NEG_MAG) begin
               fin_error = 1'b1;
            end else begin
               fin_value = '0 - v_ff;
            end
         end else if (smode_ff && v_ff[VALUE_W-1]) begin
            fin_error = 1'b1;
         end
      end
      if (fin_error) begin
         fin_value = '0;
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign job_ready = !busy_ff;
   assign load      = job_valid && job_ready;

   always_ff @(posedge clock) begin
      if (load) begin
         v_ff     <= job.accumulator;
         tens_ff  <= (job.cfg.fraction_digits > job.fraction_count)
                     ? job.cfg.fraction_digits - job.fraction_count : '0;
         pfx_ff   <= job.prefix_steps;
         neg_ff   <= job.negative;
         err_ff   <= job.error;
         bin_ff   <= job.cfg.binary_prefix;
         smode_ff <= job.cfg.signed_mode;
      end else if (busy_ff && !finishing) begin
         v_ff    <= v_in;
         tens_ff <= tens_in;
         pfx_ff  <= pfx_in;
         err_ff  <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && finishing && out_free) begin
         out_value_ff <= fin_value;
         out_error_ff <= fin_error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && finishing && out_free) begin
            busy_ff <= 1'b0;
         end
         // hold the beat until taken
         if (busy_ff && finishing && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_parsed_value = out_value_ff;
   assign rsp_parse_error  = out_error_ff;

endmodule

`default_nettype wire

### design/si_prefix_number_parser.sv
// Decimal fixed-point parser with SI prefix.
// req_ channel: one text byte per beat (req_char_code), req_last_char marks the
// final byte of a number. Bytes are taken one per cycle while req_ready is
// high; a non-last byte only updates the parse state and yields no result.
// rsp_ channel: one beat per text, rsp_parsed_value (zero on error) and
// rsp_parse_error. Results come out in text order.
// csr_ channel: csr_index 0 fraction_digits, 1 binary_prefix, 2 signed_mode;
// always ready, write only while no text is in flight.
// After the last byte is taken, the text passes through the queue to the
// scaler, which pads missing fraction digits and then applies the prefix
// steps, one multiply by 10, 1000 or 1024 per cycle, before the result is
// registered. The scaler takes a new text only once it has finished the last;
// a QUEUE_DEPTH entry queue between parser and scaler absorbs short texts.
// A stalled rsp_ready holds the result register; the scaler then stops, the
// queue fills and req_ready drops. Reset clears all parse state, the queue,
// the configuration and rsp_valid, but not the scaler data or result value.
`default_nettype none

module si_prefix_number_parser #(
   parameter int QUEUE_DEPTH = spnp_pkg::QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_char_code,
   input  wire         req_last_char,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_parsed_value,
   output logic        rsp_parse_error,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [4:0]  csr_data
);
   import spnp_pkg::*;

   cfg_type cfg_ff;
   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRACTION_DIGITS: cfg_ff.fraction_digits <= csr_data;
            CSR_BINARY_PREFIX:   cfg_ff.binary_prefix   <= csr_data[0];
            CSR_SIGNED_MODE:     cfg_ff.signed_mode     <= csr_data[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   spnp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .job_valid     (fj_valid),
      .job_ready     (fj_ready),
      .job           (fj)
   );

   spnp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fj_valid),
      .in_ready  (fj_ready),
      .in_job    (fj),
      .out_valid (bj_valid),
      .out_ready (bj_ready),
      .out_job   (bj)
   );

   spnp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (bj_valid),
      .job_ready        (bj_ready),
      .job              (bj),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_parse_error  (rsp_parse_error)
   );

endmodule

`default_nettype wire
